// ===== hw/rtl/pwcp_pkg.sv =====
// Package for the paged window cache policy unit.
// Holds command, status and register-index codes and reset defaults.
// No dependencies.
`timescale 1ns / 1ps

package pwcp_pkg;

  // Default depth of the resident map.
  localparam int MAX_PAGES_DEF = 1024;

  // Commands
  localparam logic [1:0] CMD_OPEN   = 2'd0;
  localparam logic [1:0] CMD_ACCESS = 2'd1;
  localparam logic [1:0] CMD_CLOSE  = 2'd2;
  localparam logic [1:0] CMD_NOP    = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_CUR_HIT    = 3'd0;
  localparam logic [2:0] ST_LOADED_HIT = 3'd1;
  localparam logic [2:0] ST_LOADED_NEW = 3'd2;
  localparam logic [2:0] ST_LOAD_FAIL  = 3'd3;
  localparam logic [2:0] ST_NOT_OPEN   = 3'd4;
  localparam logic [2:0] ST_OUT_RANGE  = 3'd5;
  localparam logic [2:0] ST_OPENED     = 3'd6;
  localparam logic [2:0] ST_CLOSED     = 3'd7;

  // Configuration register indexes
  localparam logic REG_CACHE_PAGES = 1'b0;
  localparam logic REG_PAGE_SHIFT  = 1'b1;

  // Register reset values
  localparam logic [10:0] CACHE_PAGES_RST = 11'd4;
  localparam logic [4:0]  PAGE_SHIFT_RST  = 5'd12;

endpackage

// ===== hw/rtl/paged_window_cache_policy_unit.sv =====
// Top level of the paged window cache policy unit: sequencer, resident map memory
// and bookkeeping registers. Depends on pwcp_pkg.
// An access hit passes S_CMD and S_CHECK from the start transfer to done, a miss with a
// free frame adds S_LOAD, and a miss that evicts adds S_EVDIR plus S_SCRD and S_SCCK per
// map entry scanned (at most MAX_PAGES). Open and a close of an open file end with the
// map clear over every entry. One item at a time: busy stays high until done; the
// receiver cannot stall results. After reset the map is cleared with busy high.
`timescale 1ns / 1ps

module paged_window_cache_policy_unit import pwcp_pkg::*; #(
  parameter int MAX_PAGES = MAX_PAGES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [31:0] byte_offset,
  input  logic [31:0] file_bytes,
  input  logic        fill_ok,
  // result channel
  output logic        done,
  output logic [2:0]  status,
  output logic [9:0]  page_index,
  output logic [15:0] offset_in_page,
  output logic        load_request,
  output logic        evict_valid,
  output logic [9:0]  evicted_page,
  // configuration write port
  input  logic        wr_en,
  input  logic        wr_index,
  input  logic [10:0] wr_data
);

  // PW indexes the map, CW holds a count up to MAX_PAGES, BW is a signed bound
  // that spans minus one up to MAX_PAGES.
  localparam int PW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CW = $clog2(MAX_PAGES + 1);
  localparam int BW = CW + 1;

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CMD   = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_EVDIR = 4'd3;
  localparam logic [3:0] S_SCRD  = 4'd4;
  localparam logic [3:0] S_SCCK  = 4'd5;
  localparam logic [3:0] S_LOAD  = 4'd6;
  localparam logic [3:0] S_CLEAR = 4'd7;

  // Reason for a map clear
  localparam logic [1:0] CLR_RESET = 2'd0;
  localparam logic [1:0] CLR_OPEN  = 2'd1;
  localparam logic [1:0] CLR_CLOSE = 2'd2;

  // Capacity is the frame count clamped to 1..MAX_PAGES.
  function automatic logic [CW-1:0] cap_of(input logic [10:0] cp);
    logic [CW-1:0] r;
    if (cp == 11'd0) begin
      r = CW'(1);
    end else if (32'(cp) > MAX_PAGES) begin
      r = CW'(MAX_PAGES);
    end else begin
      r = CW'(cp);
    end
    return r;
  endfunction

  // Configuration registers
  logic [10:0] cache_pages;
  logic [4:0]  page_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      cache_pages <= CACHE_PAGES_RST;
      page_shift  <= PAGE_SHIFT_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_CACHE_PAGES: cache_pages <= wr_data;
        REG_PAGE_SHIFT:  page_shift  <= wr_data[4:0];
        default: ;
      endcase
    end
  end

  // Page size shift clamped to 4..16.
  logic [4:0] eff_shift;
  always_comb begin
    if (page_shift < 5'd4) begin
      eff_shift = 5'd4;
    end else if (page_shift > 5'd16) begin
      eff_shift = 5'd16;
    end else begin
      eff_shift = page_shift;
    end
  end

  // Split the incoming byte position and derive the page count at the transfer.
  logic [31:0] boff_shifted;
  logic [31:0] fb_shifted;
  logic [31:0] offs_mask;
  logic [28:0] cnt_full;
  logic [CW-1:0] cnt_in;

  always_comb begin
    boff_shifted = byte_offset >> eff_shift;
    fb_shifted   = file_bytes >> eff_shift;
    offs_mask    = (32'd1 << eff_shift) - 32'd1;
    cnt_full     = {1'b0, fb_shifted[27:0]} + 29'd1;
    if (cnt_full > 29'(MAX_PAGES)) begin
      cnt_in = CW'(MAX_PAGES);
    end else begin
      cnt_in = CW'(cnt_full);
    end
  end

  // Control and bookkeeping state
  logic [3:0]     state;
  logic [1:0]     clr_kind;
  logic [PW-1:0]  clr_addr;
  logic [PW-1:0]  sidx;
  logic           scan_up;
  logic           is_open;
  logic signed [BW-1:0] low_bound;
  logic signed [BW-1:0] high_bound;
  logic [CW-1:0]  free_frames;
  logic [PW-1:0]  current_page;
  logic [CW-1:0]  page_count;

  // Latched item
  logic [1:0]     cmd_r;
  logic           ok_r;
  logic [27:0]    page_r;
  logic [CW-1:0]  cnt_r;

  // Resident map memory: one write port, one registered read port.
  logic           res_mem [MAX_PAGES];
  logic           rd_data;
  logic [PW-1:0]  rd_addr;
  logic           mem_we;
  logic [PW-1:0]  mem_wa;
  logic           mem_wd;

  logic [PW-1:0]  page_idx;
  assign page_idx = page_r[PW-1:0];

  // The item's page is read while its command is decoded; the scan reads sidx.
  assign rd_addr = (state == S_CMD) ? page_idx : sidx;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      res_mem[mem_wa] <= mem_wd;
    end
    rd_data <= res_mem[rd_addr];
  end

  // Memory writes come from the clear sweep, a found victim and a good load.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_addr;
    mem_wd = 1'b0;
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_addr;
        mem_wd = (clr_kind == CLR_OPEN) && ok_r && (clr_addr == '0);
      end
      S_SCCK: begin
        mem_we = rd_data;
        mem_wa = sidx;
        mem_wd = 1'b0;
      end
      S_LOAD: begin
        mem_we = ok_r;
        mem_wa = page_idx;
        mem_wd = 1'b1;
      end
      default: ;
    endcase
  end

  // Distance of the requested page to each bound; the scan starts at the farther one.
  logic signed [BW:0] page_sx;
  logic signed [BW:0] dl;
  logic signed [BW:0] dh;
  logic signed [BW:0] dl_abs;
  logic signed [BW:0] dh_abs;
  logic               low_past_end;
  logic signed [BW-1:0] page_s;

  always_comb begin
    page_sx = $signed((BW+1)'(page_idx));
    page_s  = $signed(BW'(page_idx));
    dl      = $signed({low_bound[BW-1], low_bound}) - page_sx;
    dh      = $signed({high_bound[BW-1], high_bound}) - page_sx;
    dl_abs  = dl[BW] ? -dl : dl;
    dh_abs  = dh[BW] ? -dh : dh;
    low_past_end = !low_bound[BW-1] && (low_bound[BW-2:0] >= (BW-1)'(MAX_PAGES));
  end

  logic [31:0] sidx_ext;
  assign sidx_ext = 32'(sidx);

  logic scan_last;
  assign scan_last = scan_up ? (sidx == PW'(MAX_PAGES - 1)) : (sidx == '0);

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_kind     <= CLR_RESET;
      clr_addr     <= '0;
      is_open      <= 1'b0;
      low_bound    <= '1;
      high_bound   <= '1;
      free_frames  <= cap_of(CACHE_PAGES_RST);
      current_page <= '0;
      page_count   <= '0;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start && (command != CMD_NOP)) begin
            cmd_r          <= command;
            ok_r           <= fill_ok;
            page_r         <= boff_shifted[27:0];
            cnt_r          <= cnt_in;
            load_request   <= 1'b0;
            evict_valid    <= 1'b0;
            evicted_page   <= '0;
            if (command == CMD_ACCESS) begin
              page_index     <= boff_shifted[9:0];
              offset_in_page <= byte_offset[15:0] & offs_mask[15:0];
            end else begin
              page_index     <= '0;
              offset_in_page <= '0;
            end
            state <= S_CMD;
          end
        end

        S_CMD: begin
          case (cmd_r)
            CMD_OPEN: begin
              // Open: clear everything, then page 0 takes one frame if the read worked.
              is_open      <= 1'b1;
              page_count   <= cnt_r;
              low_bound    <= '0;
              high_bound   <= '0;
              current_page <= '0;
              free_frames  <= ok_r ? (cap_of(cache_pages) - CW'(1)) : cap_of(cache_pages);
              load_request <= 1'b1;
              clr_kind     <= CLR_OPEN;
              clr_addr     <= '0;
              state        <= S_CLEAR;
            end
            CMD_CLOSE: begin
              if (is_open) begin
                is_open      <= 1'b0;
                page_count   <= '0;
                low_bound    <= '1;
                high_bound   <= '1;
                current_page <= '0;
                free_frames  <= cap_of(cache_pages);
                clr_kind     <= CLR_CLOSE;
                clr_addr     <= '0;
                state        <= S_CLEAR;
              end else begin
                status <= ST_NOT_OPEN;
                done   <= 1'b1;
                state  <= S_IDLE;
              end
            end
            default: begin
              if (!is_open) begin
                status <= ST_NOT_OPEN;
                done   <= 1'b1;
                state  <= S_IDLE;
              end else if (page_r >= 28'(page_count)) begin
                status <= ST_OUT_RANGE;
                done   <= 1'b1;
                state  <= S_IDLE;
              end else begin
                state <= S_CHECK;
              end
            end
          endcase
        end

        S_CHECK: begin
          if (rd_data) begin
            status       <= (page_idx == current_page) ? ST_CUR_HIT : ST_LOADED_HIT;
            current_page <= page_idx;
            done         <= 1'b1;
            state        <= S_IDLE;
          end else begin
            load_request <= 1'b1;
            state        <= (free_frames == '0) ? S_EVDIR : S_LOAD;
          end
        end

        S_EVDIR: begin
          // Pick the scan direction and its first entry; an empty range skips the scan.
          if (dl_abs > dh_abs) begin
            scan_up <= 1'b1;
            sidx    <= low_bound[BW-1] ? '0 : low_bound[PW-1:0];
            state   <= low_past_end ? S_LOAD : S_SCRD;
          end else begin
            scan_up <= 1'b0;
            sidx    <= high_bound[PW-1:0];
            state   <= high_bound[BW-1] ? S_LOAD : S_SCRD;
          end
        end

        S_SCRD: begin
          state <= S_SCCK;
        end

        S_SCCK: begin
          if (rd_data) begin
            free_frames  <= free_frames + CW'(1);
            evict_valid  <= 1'b1;
            evicted_page <= sidx_ext[9:0];
            if (scan_up) begin
              low_bound <= BW'(sidx) + BW'(1);
            end else begin
              high_bound <= BW'(sidx) - BW'(1);
            end
            state <= S_LOAD;
          end else if (scan_last) begin
            state <= S_LOAD;
          end else begin
            sidx  <= scan_up ? (sidx + PW'(1)) : (sidx - PW'(1));
            state <= S_SCRD;
          end
        end

        S_LOAD: begin
          if (ok_r) begin
            if (free_frames != '0) begin
              free_frames <= free_frames - CW'(1);
            end
            if (page_s < low_bound) begin
              low_bound <= page_s;
            end
            if (page_s > high_bound) begin
              high_bound <= page_s;
            end
            current_page <= page_idx;
            status       <= ST_LOADED_NEW;
          end else begin
            status <= ST_LOAD_FAIL;
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end

        S_CLEAR: begin
          if (clr_addr == PW'(MAX_PAGES - 1)) begin
            state <= S_IDLE;
            case (clr_kind)
              CLR_OPEN: begin
                status <= ok_r ? ST_OPENED : ST_LOAD_FAIL;
                done   <= 1'b1;
              end
              CLR_CLOSE: begin
                status <= ST_CLOSED;
                done   <= 1'b1;
              end
              default: ;
            endcase
          end else begin
            clr_addr <= clr_addr + PW'(1);
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/pwcp_checker.sv =====
// Port-level checker for the paged window cache policy unit, with its bind.
// Depends on pwcp_pkg.
`timescale 1ns / 1ps

module pwcp_port_checks import pwcp_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] command,
  input logic       done,
  input logic [2:0] status,
  input logic       load_request,
  input logic       evict_valid
);

  // A result always ends a busy period and leaves the unit free.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) && !busy))
    else $error("result transfer without a preceding busy period");

  // Every real command makes the unit busy.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (command != CMD_NOP)) |=> busy)
    else $error("accepted command did not raise busy");

  // A successful open result always carries the load request for page 0.
  a_open_loads: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_OPENED)) |-> load_request)
    else $error("open result without load request");

  // Evictions only come with a load.
  a_evict_load: assert property (@(posedge clk) disable iff (rst)
    (done && evict_valid) |->
      (load_request && ((status == ST_LOADED_NEW) || (status == ST_LOAD_FAIL))))
    else $error("eviction reported without a load");

  // Hits, refusals and closes neither load nor evict.
  a_hit_quiet: assert property (@(posedge clk) disable iff (rst)
    (done && ((status == ST_CUR_HIT) || (status == ST_LOADED_HIT) ||
              (status == ST_NOT_OPEN) || (status == ST_OUT_RANGE) ||
              (status == ST_CLOSED))) |-> (!load_request && !evict_valid))
    else $error("hit or refusal reported a load or eviction");

endmodule

bind paged_window_cache_policy_unit pwcp_port_checks u_pwcp_port_checks (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .command      (command),
  .done         (done),
  .status       (status),
  .load_request (load_request),
  .evict_valid  (evict_valid)
);

// ===== tb/pwcp_checker.sv =====
// Result checker for the paged window cache policy unit: tracks register writes,
// predicts each accepted command and compares every result transfer in order.
// Depends on pwcp_pkg.
`timescale 1ns / 1ps

module pwcp_checker import pwcp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  command,
  input  logic [31:0] byte_offset,
  input  logic [31:0] file_bytes,
  input  logic        fill_ok,
  input  logic        done,
  input  logic [2:0]  status,
  input  logic [9:0]  page_index,
  input  logic [15:0] offset_in_page,
  input  logic        load_request,
  input  logic        evict_valid,
  input  logic [9:0]  evicted_page,
  input  logic        wr_en,
  input  logic        wr_index,
  input  logic [10:0] wr_data,
  output int          outstanding,
  output int          mismatches
);

  localparam int MapDepth = MAX_PAGES_DEF;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  page;
    logic [15:0] offset;
    logic        load;
    logic        evict;
    logic [9:0]  victim;
  } page_result_t;

  logic [10:0]   frames_reg;
  logic [4:0]    shift_reg;
  bit            resident [MapDepth];
  int            lo_bound;
  int            hi_bound;
  int unsigned   free_frames;
  int unsigned   cur_page;
  int unsigned   file_pages;
  bit            file_open;
  page_result_t  pending_q[$];
  int            errors = 0;

  function automatic int unsigned frame_capacity();
    int unsigned c;
    c = frames_reg;
    if (c < 1) c = 1;
    if (c > MapDepth) c = MapDepth;
    return c;
  endfunction

  function automatic int unsigned page_bits();
    int unsigned s;
    s = shift_reg;
    if (s < 4) s = 4;
    if (s > 16) s = 16;
    return s;
  endfunction

  function automatic void drop_file();
    foreach (resident[i]) resident[i] = 1'b0;
    lo_bound = -1;
    hi_bound = -1;
    free_frames = frame_capacity();
    cur_page = 0;
    file_pages = 0;
    file_open = 1'b0;
  endfunction

  function automatic bit resident_at(int idx);
    return idx >= 0 && idx < MapDepth && resident[idx];
  endfunction

  // Walks inward from the bound farther from the requested page and frees the
  // first resident page found.
  function automatic bit pick_victim(int unsigned page, output logic [31:0] victim);
    int p;
    int dl;
    int dh;
    int idx;
    p = int'(page);
    dl = lo_bound - p;
    dh = hi_bound - p;
    victim = '0;
    if (dl < 0) dl = -dl;
    if (dh < 0) dh = -dh;
    if (dl > dh) begin
      idx = lo_bound;
      for (int n = 0; n < MapDepth + 2; n++) begin
        if (resident_at(idx)) begin
          resident[idx] = 1'b0;
          free_frames++;
          lo_bound = idx + 1;
          victim = idx;
          return 1'b1;
        end
        idx++;
      end
    end else begin
      idx = hi_bound;
      for (int n = 0; n < MapDepth + 2; n++) begin
        if (resident_at(idx)) begin
          resident[idx] = 1'b0;
          free_frames++;
          hi_bound = idx - 1;
          victim = idx;
          return 1'b1;
        end
        idx--;
      end
    end
    return 1'b0;
  endfunction

  // A failed fill leaves the page absent, but an eviction made for it stands.
  function automatic logic [2:0] fetch_page(int unsigned page, bit ok,
                                            inout page_result_t r);
    logic [31:0] victim;
    if (free_frames == 0 && pick_victim(page, victim)) begin
      r.evict = 1'b1;
      r.victim = victim[9:0];
    end
    if (!ok || page >= MapDepth) return ST_LOAD_FAIL;
    resident[page] = 1'b1;
    if (free_frames > 0) free_frames--;
    if (int'(page) < lo_bound) lo_bound = page;
    if (int'(page) > hi_bound) hi_bound = page;
    cur_page = page;
    return ST_LOADED_NEW;
  endfunction

  function automatic bit predict_transfer(logic [1:0] cmd, logic [31:0] boff,
                                          logic [31:0] fbytes, bit ok,
                                          output page_result_t r);
    int unsigned sh;
    int unsigned cnt;
    logic [31:0] page;
    r = '0;
    sh = page_bits();
    case (cmd)
      CMD_NOP: return 1'b0;
      CMD_OPEN: begin
        drop_file();
        cnt = (fbytes >> sh) + 1;
        if (cnt > MapDepth) cnt = MapDepth;
        file_pages = cnt;
        file_open = 1'b1;
        lo_bound = 0;
        hi_bound = 0;
        r.load = 1'b1;
        r.status = (fetch_page(0, ok, r) == ST_LOADED_NEW) ? ST_OPENED : ST_LOAD_FAIL;
      end
      CMD_CLOSE: begin
        if (file_open) begin
          drop_file();
          r.status = ST_CLOSED;
        end else begin
          r.status = ST_NOT_OPEN;
        end
      end
      default: begin
        page = boff >> sh;
        r.page = page[9:0];
        r.offset = 16'(boff & ((32'd1 << sh) - 32'd1));
        if (!file_open) begin
          r.status = ST_NOT_OPEN;
        end else if (page >= file_pages || page >= MapDepth) begin
          r.status = ST_OUT_RANGE;
        end else if (resident[page]) begin
          r.status = (page == cur_page) ? ST_CUR_HIT : ST_LOADED_HIT;
          cur_page = page;
        end else begin
          r.load = 1'b1;
          r.status = fetch_page(page, ok, r);
        end
      end
    endcase
    return 1'b1;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    page_result_t want;
    page_result_t got;
    page_result_t fresh;
    if (rst) begin
      frames_reg = CACHE_PAGES_RST;
      shift_reg = PAGE_SHIFT_RST;
      drop_file();
      pending_q.delete();
    end else begin
      if (done) begin
        got = {status, page_index, offset_in_page, load_request, evict_valid,
               evicted_page};
        if (pending_q.size() == 0) begin
          errors++;
          $display("%0t: result transfer mismatch, expected no result, got status %0d",
                   $time, got.status);
        end else begin
          want = pending_q.pop_front();
          check_field("status", want.status, got.status);
          check_field("page_index", want.page, got.page);
          check_field("offset_in_page", want.offset, got.offset);
          check_field("load_request", want.load, got.load);
          check_field("evict_valid", want.evict, got.evict);
          check_field("evicted_page", want.victim, got.victim);
        end
      end
      if (wr_en) begin
        if (wr_index == REG_CACHE_PAGES) frames_reg = wr_data;
        else shift_reg = wr_data[4:0];
      end
      if (start && !busy) begin
        if (predict_transfer(command, byte_offset, file_bytes, fill_ok, fresh))
          pending_q.push_back(fresh);
      end
    end
    outstanding <= pending_q.size();
    mismatches <= errors;
  end

endmodule

// ===== tb/tb_paged_window_cache_policy_unit.sv =====
// Testbench top for the paged window cache policy unit: clock, reset, command
// stimulus, register writes and the verdict. Depends on pwcp_pkg and pwcp_checker.
`timescale 1ns / 1ps

module tb_paged_window_cache_policy_unit import pwcp_pkg::*;;

  localparam int NumPhases = 9;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  command = CMD_NOP;
  logic [31:0] byte_offset = '0;
  logic [31:0] file_bytes = '0;
  logic        fill_ok = 1'b0;
  logic        done;
  logic [2:0]  status;
  logic [9:0]  page_index;
  logic [15:0] offset_in_page;
  logic        load_request;
  logic        evict_valid;
  logic [9:0]  evicted_page;
  logic        wr_en = 1'b0;
  logic        wr_index = REG_CACHE_PAGES;
  logic [10:0] wr_data = '0;
  int          outstanding;
  int          mismatches;

  // Per-phase settings: frame count, page shift, number of commands and the
  // largest file (in pages) that the well-formed opens create. Out-of-range
  // register values are included so the clamping gets exercised at both ends.
  int frame_set [NumPhases] = '{1, 2, 3, 1024, 2047, 0, 5, 1, 8};
  int shift_set [NumPhases] = '{4, 0, 8, 16, 31, 5, 12, 16, 10};
  int count_set [NumPhases] = '{260, 260, 260, 150, 60, 260, 260, 60, 300};
  int span_set  [NumPhases] = '{8, 12, 16, 64, 1024, 6, 24, 1024, 32};

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  paged_window_cache_policy_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .command        (command),
    .byte_offset    (byte_offset),
    .file_bytes     (file_bytes),
    .fill_ok        (fill_ok),
    .done           (done),
    .status         (status),
    .page_index     (page_index),
    .offset_in_page (offset_in_page),
    .load_request   (load_request),
    .evict_valid    (evict_valid),
    .evicted_page   (evicted_page),
    .wr_en          (wr_en),
    .wr_index       (wr_index),
    .wr_data        (wr_data)
  );

  pwcp_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .command        (command),
    .byte_offset    (byte_offset),
    .file_bytes     (file_bytes),
    .fill_ok        (fill_ok),
    .done           (done),
    .status         (status),
    .page_index     (page_index),
    .offset_in_page (offset_in_page),
    .load_request   (load_request),
    .evict_valid    (evict_valid),
    .evicted_page   (evicted_page),
    .wr_en          (wr_en),
    .wr_index       (wr_index),
    .wr_data        (wr_data),
    .outstanding    (outstanding),
    .mismatches     (mismatches)
  );

  // Presents one command and returns at the edge where it was taken. Start is
  // left high, so a following call keeps the command channel full without
  // lowering and raising start in the same step.
  task automatic issue(input logic [1:0] cmd, input logic [31:0] boff,
                       input logic [31:0] fbytes, input logic ok);
    start <= 1'b1;
    command <= cmd;
    byte_offset <= boff;
    file_bytes <= fbytes;
    fill_ok <= ok;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Waits until every predicted result has come back and the block is idle.
  // A no-op command produces no result and does not make the block busy.
  task automatic settle_idle();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Writes the frame count register, then the page shift register, while the block is idle.
  task automatic write_config(input logic [10:0] frames, input logic [4:0] shift);
    wr_en <= 1'b1;
    wr_index <= REG_CACHE_PAGES;
    wr_data <= frames;
    @(posedge clk);
    wr_index <= REG_PAGE_SHIFT;
    wr_data <= {6'd0, shift};
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  initial begin
    #400_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int unsigned sh;
    logic [31:0] mask;
    logic [31:0] boff;
    logic [31:0] fbytes;
    logic [1:0]  cmd;
    logic        ok;
    int          r;
    int          sent;
    int          page;
    int          last_page;
    int          file_span;
    int          pages;
    int unsigned full_count;
    bit          open_now;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // The map is cleared after reset with busy high; let that pass first.
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);

    // Directed part under the reset settings: four frames, 4 KiB pages.
    issue(CMD_ACCESS, 32'hFFFF_FFFF, 32'h0, 1'b1);      // access with no file open
    issue(CMD_CLOSE, 32'h0, 32'hFFFF_FFFF, 1'b1);       // close with no file open
    issue(CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1); // ignored command
    issue(CMD_OPEN, 32'h0, 32'h0, 1'b0);                // open whose first fill fails
    issue(CMD_ACCESS, 32'h0000_0ABC, 32'h0, 1'b1);      // page 0 is not resident yet
    issue(CMD_OPEN, 32'h0, 32'hFFFF_FFFF, 1'b1);        // reopen, page count saturates
    issue(CMD_ACCESS, 32'h0000_0000, 32'h0, 1'b1);      // current hit
    issue(CMD_ACCESS, 32'h0000_1FFF, 32'h0, 1'b1);      // last byte of page 1
    issue(CMD_ACCESS, 32'h0000_2000, 32'h0, 1'b1);
    issue(CMD_ACCESS, 32'h0000_3FFF, 32'h0, 1'b1);      // all four frames now taken
    issue(CMD_ACCESS, 32'h003F_F000, 32'h0, 1'b0);      // eviction, then a failed fill
    issue(CMD_ACCESS, 32'h003F_FFFF, 32'h0, 1'b1);      // top page loads into the freed frame
    issue(CMD_ACCESS, 32'h0000_2345, 32'h0, 1'b1);      // hit on another resident page
    issue(CMD_ACCESS, 32'h001F_4000, 32'h0, 1'b1);      // eviction scanning from the top
    issue(CMD_ACCESS, 32'h0040_0000, 32'h0, 1'b1);      // first page past the file
    issue(CMD_ACCESS, 32'hFFFF_FFFF, 32'h0, 1'b0);      // far out of range
    issue(CMD_CLOSE, 32'h0, 32'h0, 1'b1);
    issue(CMD_ACCESS, 32'h0000_0005, 32'h0, 1'b1);      // access after close
    issue(CMD_OPEN, 32'h0, 32'h0000_2FFF, 1'b1);        // three-page file
    issue(CMD_ACCESS, 32'h0000_3000, 32'h0, 1'b1);      // one page past the end
    issue(CMD_ACCESS, 32'h0000_2FFF, 32'h0, 1'b0);      // last page, fill fails
    issue(CMD_NOP, 32'h0, 32'h0, 1'b0);
    issue(CMD_CLOSE, 32'h0, 32'h0, 1'b0);

    open_now = 1'b0;
    file_span = 1;
    last_page = 0;

    // Random phases. Each starts from an idle block with fresh register values;
    // a file left open from the previous phase carries over, so a new page size
    // meets a page count computed under the old one.
    for (int ph = 0; ph < NumPhases; ph++) begin
      settle_idle();
      write_config(11'(frame_set[ph]), 5'(shift_set[ph]));
      sh = shift_set[ph];
      if (sh < 4) sh = 4;
      if (sh > 16) sh = 16;
      mask = (32'd1 << sh) - 1;
      if (file_span > span_set[ph]) file_span = span_set[ph];
      if (last_page >= file_span) last_page = 0;
      sent = 0;
      while (sent < count_set[ph]) begin
        // Short idle bursts on the command side, none in the final phase.
        if (ph != NumPhases - 1 && $urandom_range(0, 3) == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        r = $urandom_range(0, 99);
        ok = ($urandom_range(0, 9) != 0);
        boff = $urandom;
        fbytes = $urandom;
        cmd = CMD_ACCESS;
        // Mostly well-formed traffic: open a file, then access it with some
        // locality. The rest is reopen, close, no-op and random offsets.
        if (open_now ? r < 3 : r < 85) begin
          cmd = CMD_OPEN;
          if ($urandom_range(0, 9) != 0) begin
            pages = $urandom_range(1, span_set[ph]);
            fbytes = (32'(pages - 1) << sh) | (fbytes & mask);
          end
          full_count = (fbytes >> sh) + 1;
          file_span = (full_count > 32'(span_set[ph])) ? span_set[ph] : int'(full_count);
          open_now = 1'b1;
          last_page = 0;
        end else if (open_now ? r < 6 : r < 90) begin
          cmd = CMD_CLOSE;
          open_now = 1'b0;
        end else if (open_now ? r < 8 : r < 93) begin
          cmd = CMD_NOP;
        end else if (open_now && r >= 12) begin
          if ($urandom_range(0, 99) < 3) begin
            page = file_span;
          end else if ($urandom_range(0, 1) == 1) begin
            page = last_page + int'($urandom_range(0, 4)) - 2;
            if (page < 0) page = 0;
            if (page > file_span - 1) page = file_span - 1;
          end else begin
            page = $urandom_range(0, file_span - 1);
          end
          last_page = (page < file_span) ? page : last_page;
          boff = (32'(page) << sh) | (boff & mask);
        end
        issue(cmd, boff, fbytes, ok);
        if (cmd != CMD_NOP) sent++;
      end
    end

    // Drain, then allow the longest eviction scan for any stray result.
    settle_idle();
    repeat (2 * MAX_PAGES_DEF + 100) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/pwcp_pkg.sv
hw/rtl/paged_window_cache_policy_unit.sv
hw/rtl/pwcp_checker.sv
tb/pwcp_checker.sv
tb/tb_paged_window_cache_policy_unit.sv
